[rtl/square_channel_sweep_duty_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the square channel with frequency sweep
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SQUARE_CHANNEL_SWEEP_DUTY_DEFINES_SVH
`define SQUARE_CHANNEL_SWEEP_DUTY_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCSD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SCSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCSD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SCSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/scsd_pkg.sv]
// ---------------------------------------------------------------------------
// scsd_pkg
// Types, codes and the duty pattern table shared by the sweep square channel.
// ---------------------------------------------------------------------------
package scsd_pkg;

  // command codes of an input beat
  localparam logic [1:0] CMD_ADVANCE = 2'd0;
  localparam logic [1:0] CMD_SWEEP   = 2'd1;
  localparam logic [1:0] CMD_FREQ_LO = 2'd2;
  localparam logic [1:0] CMD_FREQ_HI = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_SWEEP_PERIOD = 3'd0;
  localparam logic [2:0] CFG_SWEEP_NEGATE = 3'd1;
  localparam logic [2:0] CFG_SWEEP_SHIFT  = 3'd2;
  localparam logic [2:0] CFG_DUTY_MODE    = 3'd3;
  localparam logic [2:0] CFG_POWER_ON     = 3'd4;

  // bit i is the level at duty position i
  localparam logic [7:0] DUTY_TABLE [4] = '{
    8'b1000_0000,
    8'b1000_0001,
    8'b1110_0001,
    8'b0111_1110
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ticks;
    logic [7:0] data;
    logic       trigger;
  } in_item_t;

  typedef struct packed {
    logic        duty_bit;
    logic [2:0]  duty_step;
    logic [10:0] frequency_now;
    logic        channel_off;
  } out_item_t;

  typedef struct packed {
    logic [2:0] sweep_period;
    logic       sweep_negate;
    logic [2:0] sweep_shift;
    logic [1:0] duty_mode;
    logic       power_on;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_TIME_START,
    DP_TIME_STEP,
    DP_TIME_END,
    DP_SWEEP_DEC,
    DP_SWEEP_RELOAD,
    DP_SWEEP_APPLY,
    DP_CHECK,
    DP_FREQ_LO,
    DP_FREQ_HI,
    DP_RESTART,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clear_off;
  } dp_cmd_t;

  typedef struct packed {
    logic time_expired;
    logic sweep_idle;
    logic sweep_count;
    logic over;
    logic shift_zero;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/scsd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// scsd_cfg_regs
// Configuration register file, written one register per beat.
// ---------------------------------------------------------------------------
module scsd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output scsd_pkg::cfg_t cfg
);
  import scsd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{sweep_period: 3'd0, sweep_negate: 1'b0, sweep_shift: 3'd0,
               duty_mode: 2'd0, power_on: 1'b1};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SWEEP_PERIOD: cfg.sweep_period <= cfg_data[2:0];
        CFG_SWEEP_NEGATE: cfg.sweep_negate <= cfg_data[0];
        CFG_SWEEP_SHIFT:  cfg.sweep_shift  <= cfg_data[2:0];
        CFG_DUTY_MODE:    cfg.duty_mode    <= cfg_data[1:0];
        CFG_POWER_ON:     cfg.power_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/scsd_dp.sv]
// ---------------------------------------------------------------------------
// scsd_dp
// Channel state, period timer loop, sweep unit and output register.
// ---------------------------------------------------------------------------
module scsd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  scsd_pkg::cfg_t       cfg,
  input  scsd_pkg::in_item_t   in_data,
  input  scsd_pkg::dp_cmd_t    cmd,
  output scsd_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scsd_pkg::out_item_t  out_data
);
  import scsd_pkg::*;

  logic [10:0]        frequency;
  logic [10:0]        shadow;
  logic [14:0]        period_timer;
  logic [2:0]         duty_pos;
  logic [3:0]         sweep_timer;
  logic               sweep_active;
  logic signed [15:0] t;
  logic               off;

  logic [10:0] delta;
  logic [11:0] nf;
  logic [15:0] period;

  // sweep candidate from the shadow frequency
  assign delta  = shadow >> cfg.sweep_shift;
  assign nf     = cfg.sweep_negate ? ({1'b0, shadow} - {1'b0, delta})
                                   : ({1'b0, shadow} + {1'b0, delta});
  assign period = {2'b00, 12'(12'd2048 - {1'b0, frequency}), 2'b00};

  assign status.time_expired = t[15] || (t == 16'sd0);
  assign status.sweep_idle   = !sweep_active || (cfg.sweep_period == 3'd0);
  assign status.sweep_count  = sweep_timer > 4'd1;
  assign status.over         = nf[11];
  assign status.shift_zero   = cfg.sweep_shift == 3'd0;
  assign status.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency    <= '0;
      shadow       <= '0;
      period_timer <= '0;
      duty_pos     <= '0;
      sweep_timer  <= '0;
      sweep_active <= 1'b0;
      t            <= '0;
      off          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear_off) begin
        off <= 1'b0;
      end
      case (cmd.op)
        DP_TIME_START: t <= $signed({1'b0, period_timer}) - $signed({8'd0, in_data.ticks});
        DP_TIME_STEP: begin
          t        <= t + $signed(period);
          duty_pos <= duty_pos + 3'd1;
        end
        DP_TIME_END:  period_timer <= t[14:0];
        DP_SWEEP_DEC: sweep_timer <= sweep_timer - 4'd1;
        DP_SWEEP_RELOAD: begin
          sweep_timer <= sweep_timer + {1'b0, cfg.sweep_period} - 4'd1;
          shadow      <= frequency;
        end
        DP_SWEEP_APPLY: begin
          frequency <= nf[10:0];
          shadow    <= nf[10:0];
        end
        DP_CHECK:   off <= nf[11];
        DP_FREQ_LO: frequency[7:0] <= in_data.data;
        DP_FREQ_HI: frequency[10:8] <= in_data.data[2:0];
        DP_RESTART: begin
          frequency[10:8] <= in_data.data[2:0];
          shadow          <= {in_data.data[2:0], frequency[7:0]};
          sweep_timer     <= {1'b0, cfg.sweep_period};
          sweep_active    <= !((cfg.sweep_period == 3'd0) && (cfg.sweep_shift == 3'd0));
        end
        default: ;
      endcase
      // output register: load on emit, drop once taken
      if (cmd.op == DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_data.duty_bit      <= DUTY_TABLE[cfg.duty_mode][duty_pos];
      out_data.duty_step     <= duty_pos;
      out_data.frequency_now <= frequency;
      out_data.channel_off   <= off;
    end
  end

endmodule

[rtl/scsd_ctrl.sv]
// ---------------------------------------------------------------------------
// scsd_ctrl
// Command sequencer: decodes a beat and steps the datapath through it.
// ---------------------------------------------------------------------------
module scsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scsd_pkg::in_item_t   in_data,
  input  scsd_pkg::cfg_t       cfg,
  input  scsd_pkg::dp_status_t status,
  output scsd_pkg::dp_cmd_t    cmd
);
  import scsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_SWEEP_APPLY,
    ST_SWEEP_CHECK,
    ST_RESTART_CHECK,
    ST_EMIT
  } state_t;

  state_t state, state_next;
  logic   busy;

  assign in_stall = busy;

  always_comb begin
    state_next    = state;
    cmd.op        = DP_NONE;
    cmd.clear_off = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.clear_off = 1'b1;
          state_next    = ST_EMIT;
          case (in_data.cmd)
            CMD_ADVANCE: begin
              cmd.op     = DP_TIME_START;
              state_next = ST_TIME;
            end
            CMD_SWEEP: begin
              if (status.sweep_idle) begin
                cmd.op = DP_NONE;
              end else if (status.sweep_count) begin
                cmd.op = DP_SWEEP_DEC;
              end else begin
                cmd.op     = DP_SWEEP_RELOAD;
                state_next = ST_SWEEP_APPLY;
              end
            end
            CMD_FREQ_LO: begin
              if (cfg.power_on) begin
                cmd.op = DP_FREQ_LO;
              end
            end
            CMD_FREQ_HI: begin
              if (cfg.power_on && in_data.trigger) begin
                cmd.op     = DP_RESTART;
                state_next = ST_RESTART_CHECK;
              end else if (cfg.power_on) begin
                cmd.op = DP_FREQ_HI;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TIME: begin
        if (status.time_expired) begin
          cmd.op = DP_TIME_STEP;
        end else begin
          cmd.op     = DP_TIME_END;
          state_next = ST_EMIT;
        end
      end
      ST_SWEEP_APPLY: begin
        state_next = ST_EMIT;
        if (status.over) begin
          cmd.op = DP_CHECK;
        end else if (!status.shift_zero) begin
          cmd.op     = DP_SWEEP_APPLY;
          state_next = ST_SWEEP_CHECK;
        end
      end
      ST_SWEEP_CHECK: begin
        cmd.op     = DP_CHECK;
        state_next = ST_EMIT;
      end
      ST_RESTART_CHECK: begin
        if (!status.shift_zero) begin
          cmd.op = DP_CHECK;
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = DP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != ST_IDLE;
    end
  end

endmodule

[rtl/square_channel_sweep_duty.sv]
// ---------------------------------------------------------------------------
// square_channel_sweep_duty
// Square-wave channel with frequency sweep and 8-step duty sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   beat: advance time, clock the sweep, write the low frequency byte, or
//   write the high frequency bits with an optional trigger. Every input beat
//   yields exactly one output beat (out_valid / out_stall / out_data) with
//   the duty level, duty position, current frequency and overflow pulse.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; write it only while no command is in flight.
// Sequence:
//   Time advance resolves one period-timer wrap per cycle by the timer
//   adder in the datapath (up to 64 wraps for 255 ticks at the shortest
//   period of 4). A sweep clock decrements or reloads the sweep timer; a
//   reload checks for overflow and, with a nonzero shift, applies the
//   shift-and-add. A trigger with a nonzero shift checks for overflow too.
//   The next command is taken once the result is in the output register.
// Reset: rst is synchronous; all channel state clears, power_on sets.
// Stall: a stalled output beat holds; the sequencer waits with in_stall high
//   until the output register frees up.
// ---------------------------------------------------------------------------
`include "square_channel_sweep_duty_defines.svh"

module square_channel_sweep_duty (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  scsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import scsd_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // register file for the sweep, duty and power controls
  scsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: decode a beat, step the timer loop and the sweep unit
  scsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .status   (status),
    .cmd      (cmd)
  );

  // channel state, arithmetic and output register
  scsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted beat always needs further cycles before the next one
  `SCSD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "input taken while busy")
  // a new result comes only out of the sequencer's emit step
  `SCSD_ASSERT_SAME(a_emit_from_busy, clk, rst, $rose(out_valid), $past(in_stall), "result without command")
  // the sequencer never emits into a full, stalled output register
  `SCSD_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.op == DP_EMIT, !out_valid || !out_stall, "result overwritten")

endmodule
